// ===== rtl/core/iir_direct_form_one_filter_unit_macros.svh =====
// Assertion macros shared by the IIR filter unit RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IIR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define IIR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/iir_pkg.sv =====
// Types, constants and the control program of the IIR filter unit.
// No dependencies; the sequencer, divider, datapath and top module import this package.
package iir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int NREGS     = 8;
    localparam int REG_IDX_W = 4;
    localparam int TAP_W     = 3;
    localparam int PC_W      = 4;
    localparam int CNT_W     = $clog2(ACC_W + 1);

    // Register indexes of the configuration port
    localparam logic [2:0] REG_B0 = 3'd0;
    localparam logic [2:0] REG_A0 = 3'd4;

    // Q8.16 one, reset value of b0 and a0
    localparam logic [COEF_W-1:0] COEF_ONE = 24'd65536;

    // Saturation bounds on the quotient magnitude
    localparam logic [ACC_W-1:0] POS_LIMIT = ACC_W'(32767);
    localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [NREGS-1:0][COEF_W-1:0] coef_bank_t;

    // Reset bank: b0 (entry 0) and a0 (entry 4) at one, every other entry zero
    localparam coef_bank_t COEF_BANK_RESET = {{3{COEF_W'(0)}}, COEF_ONE,
                                              {3{COEF_W'(0)}}, COEF_ONE};

    typedef struct packed {
        sample_t sample_in;
    } in_item_t;

    typedef struct packed {
        sample_t sample_out;
        logic    saturated;
        logic    divisor_zero;
    } out_item_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_MAC,
        UOP_DIV_LOAD,
        UOP_DIV_STEP,
        UOP_RETIRE
    } uop_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_DIV_DONE,
        COND_OUT_FREE
    } cond_t;

    // Taps: 0 = x[n], 1..3 = x[n-1..n-3], 4..6 = y[n-1..n-3]
    localparam logic [TAP_W-1:0] TAP_X0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_X1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_X2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_X3 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_Y1 = 3'd4;
    localparam logic [TAP_W-1:0] TAP_Y2 = 3'd5;
    localparam logic [TAP_W-1:0] TAP_Y3 = 3'd6;

    typedef struct packed {
        uop_t             op;
        logic [TAP_W-1:0] tap;
        acc_op_t          acc_op;
        cond_t            cond;
        logic [PC_W-1:0]  next_pc;
    } ucode_t;

    // Control word handed from the sequencer to the datapath and divider
    typedef struct packed {
        uop_t             op;
        logic [TAP_W-1:0] tap;
        acc_op_t          acc_op;
        logic             go;
    } ctrl_t;

    // Status returned to the sequencer for its conditional jumps
    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic out_free;
    } stat_t;

    // Coefficient register that goes with a tap (a0 is skipped)
    function automatic logic [2:0] tap_coef(input logic [TAP_W-1:0] tap);
        logic [2:0] idx;
        idx = (tap < TAP_Y1) ? tap : tap + 3'd1;
        return idx;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{UOP_ACCEPT,   TAP_X0, ACC_HOLD, COND_IN_VALID, 4'd1};
            4'd1:    w = '{UOP_MAC,      TAP_X0, ACC_HOLD, COND_ALWAYS,   4'd2};
            4'd2:    w = '{UOP_MAC,      TAP_X1, ACC_ADD,  COND_ALWAYS,   4'd3};
            4'd3:    w = '{UOP_MAC,      TAP_X2, ACC_ADD,  COND_ALWAYS,   4'd4};
            4'd4:    w = '{UOP_MAC,      TAP_X3, ACC_ADD,  COND_ALWAYS,   4'd5};
            4'd5:    w = '{UOP_MAC,      TAP_Y1, ACC_ADD,  COND_ALWAYS,   4'd6};
            4'd6:    w = '{UOP_MAC,      TAP_Y2, ACC_SUB,  COND_ALWAYS,   4'd7};
            4'd7:    w = '{UOP_MAC,      TAP_Y3, ACC_SUB,  COND_ALWAYS,   4'd8};
            4'd8:    w = '{UOP_NOP,      TAP_X0, ACC_SUB,  COND_ALWAYS,   4'd9};
            4'd9:    w = '{UOP_DIV_LOAD, TAP_X0, ACC_HOLD, COND_ALWAYS,   4'd10};
            4'd10:   w = '{UOP_DIV_STEP, TAP_X0, ACC_HOLD, COND_DIV_DONE, 4'd11};
            4'd11:   w = '{UOP_RETIRE,   TAP_X0, ACC_HOLD, COND_OUT_FREE, 4'd0};
            default: w = '{UOP_NOP,      TAP_X0, ACC_HOLD, COND_ALWAYS,   4'd0};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/iir_stream_if.sv =====
// Valid/ready stream channel used for the sample and result transactions.
// The payload type is set per instance; no package dependency.
interface iir_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/iir_seq.sv =====
// Microcode sequencer: program counter, control store and jump conditions.
// Depends on iir_pkg.
module iir_seq
    import iir_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            cond_met;

    always_comb
    begin
        word = ucode_rom(pc_reg);
        case (word.cond)
            COND_ALWAYS:   cond_met = 1'b1;
            COND_IN_VALID: cond_met = stat.in_valid;
            COND_DIV_DONE: cond_met = stat.div_done;
            COND_OUT_FREE: cond_met = stat.out_free;
            default:       cond_met = 1'b1;
        endcase
        // stay on the step until its condition holds
        pc_next     = cond_met ? word.next_pc : pc_reg;
        ctrl.op     = word.op;
        ctrl.tap    = word.tap;
        ctrl.acc_op = word.acc_op;
        ctrl.go     = cond_met;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/iir_div.sv =====
// Serial restoring divider: one quotient bit per cycle on magnitudes.
// Depends on iir_pkg.
module iir_div
    import iir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  acc_t             dividend,
    input  coef_t            divisor,
    output logic [ACC_W-1:0] quotient,
    output logic             q_neg,
    output logic             done
);

    logic [ACC_W-1:0]  quo_reg;
    logic [COEF_W-1:0] dvs_reg;
    logic [COEF_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [COEF_W:0]   rem_sh;
    logic [COEF_W:0]   rem_diff;
    logic              q_bit;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.op == UOP_DIV_LOAD && ctrl.go)
        begin
            cnt_reg <= CNT_W'(ACC_W);
        end
        else if (ctrl.op == UOP_DIV_STEP && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == UOP_DIV_LOAD && ctrl.go)
        begin
            quo_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            dvs_reg <= divisor[COEF_W-1] ? COEF_W'(-divisor) : COEF_W'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[ACC_W-1] ^ divisor[COEF_W-1];
        end
        else if (ctrl.op == UOP_DIV_STEP && cnt_reg != '0)
        begin
            // remainder stays below the divisor, so its top bit drops out
            rem_reg <= q_bit ? rem_diff[COEF_W-1:0] : rem_sh[COEF_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], q_bit};
        end
    end

    assign quotient = quo_reg;
    assign q_neg    = neg_reg;
    assign done     = (cnt_reg == '0);

endmodule

// ===== rtl/core/iir_dp.sv =====
// Datapath: sample history, shared multiplier, accumulator and output saturation.
// Depends on iir_pkg; driven by the control word from iir_seq.
module iir_dp
    import iir_pkg::*;
#(
    parameter int ORDER = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  sample_t          sample_in,
    input  coef_bank_t       coefs,
    input  logic [ACC_W-1:0] quotient,
    input  logic             q_neg,
    output acc_t             acc,
    output out_item_t        item
);

    sample_t x_reg;
    sample_t x_hist_reg [ORDER];
    sample_t y_hist_reg [ORDER];
    prod_t   prod_reg;
    acc_t    acc_reg;
    acc_t    acc_next;
    sample_t opnd;
    coef_t   coef_sel;
    prod_t   prod_next;
    coef_t   a0;

    assign a0 = coef_t'(coefs[REG_A0]);

    // operand and coefficient for the current tap; x and y history taps past ORDER read zero
    always_comb
    begin
        opnd = '0;
        if (ctrl.tap == TAP_X0)
        begin
            opnd = x_reg;
        end
        for (int i = 0; i < ORDER; i++)
        begin
            if (ctrl.tap == TAP_W'(1 + i))
            begin
                opnd = x_hist_reg[i];
            end
            if (ctrl.tap == TAP_W'(4 + i))
            begin
                opnd = y_hist_reg[i];
            end
        end
        coef_sel  = coef_t'(coefs[tap_coef(ctrl.tap)]);
        prod_next = coef_sel * opnd;
    end

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_SUB:  acc_next = acc_reg - ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    // saturate the quotient, or force zero on a zero divisor
    always_comb
    begin
        item.sample_out   = '0;
        item.saturated    = 1'b0;
        item.divisor_zero = 1'b0;
        if (a0 == '0)
        begin
            item.divisor_zero = 1'b1;
        end
        else if (!q_neg)
        begin
            if (quotient > POS_LIMIT)
            begin
                item.sample_out = SAMPLE_MAX;
                item.saturated  = 1'b1;
            end
            else
            begin
                item.sample_out = sample_t'(quotient[SAMPLE_W-1:0]);
            end
        end
        else
        begin
            if (quotient > NEG_LIMIT)
            begin
                item.sample_out = SAMPLE_MIN;
                item.saturated  = 1'b1;
            end
            else
            begin
                item.sample_out = sample_t'(~quotient[SAMPLE_W-1:0] + 16'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else if (ctrl.op == UOP_RETIRE && ctrl.go)
        begin
            x_hist_reg[0] <= x_reg;
            y_hist_reg[0] <= item.sample_out;
            for (int i = 1; i < ORDER; i++)
            begin
                x_hist_reg[i] <= x_hist_reg[i-1];
                y_hist_reg[i] <= y_hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == UOP_ACCEPT && ctrl.go)
        begin
            x_reg   <= sample_in;
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.op == UOP_MAC)
        begin
            prod_reg <= prod_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/core/iir_direct_form_one_filter_unit.sv =====
// Third-order direct form I IIR filter. Each sample transaction on samples gives
// one result transaction on results: y = (b0*x[n] + b1..b3 * x[n-1..n-3]
// - a1..a3 * y[n-1..n-3]) / a0, truncated toward zero and saturated to 16 bits;
// a zero a0 gives 0 with divisor_zero set. Coefficients are signed Q8.16 and must be
// written through cfg_we/cfg_index/cfg_data by the user while the unit is idle; the
// block itself does not enforce this. Indexes above 7 are dropped. A sample runs
// through one accept step, seven passes through the single shared 24x16 multiplier,
// two accumulate and load steps, the serial divider (one quotient bit per cycle over
// the 42-bit sum) and one retire step, which waits until the output register is free.
// The next sample is taken as soon as the program returns to its accept step, even
// while the previous result still waits in the output register.
// Depends on iir_pkg, iir_stream_if, iir_seq, iir_dp, iir_div and the macros header.
`include "iir_direct_form_one_filter_unit_macros.svh"

module iir_direct_form_one_filter_unit
    import iir_pkg::*;
#(
    parameter int ORDER = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    iir_stream_if.sink           samples,
    iir_stream_if.source         results,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    coef_bank_t       coef_reg;
    ctrl_t            ctrl;
    stat_t            stat;
    acc_t             acc;
    out_item_t        item;
    logic [ACC_W-1:0] quotient;
    logic             q_neg;
    logic             div_done;
    logic             retire;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    // Configuration: hold the coefficient bank, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_BANK_RESET;
        end
        else if (cfg_we && cfg_index < REG_IDX_W'(NREGS))
        begin
            coef_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Sample side: ready only on the accept step of the program
    assign samples.ready = (ctrl.op == UOP_ACCEPT);

    // Result side: the output register frees up when its transaction completes
    assign stat.in_valid = samples.valid;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || results.ready;
    assign retire        = (ctrl.op == UOP_RETIRE) && ctrl.go;

    iir_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    iir_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample_in (samples.payload.sample_in),
        .coefs     (coef_reg),
        .quotient  (quotient),
        .q_neg     (q_neg),
        .acc       (acc),
        .item      (item)
    );

    iir_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .dividend (acc),
        .divisor  (coef_t'(coef_reg[REG_A0])),
        .quotient (quotient),
        .q_neg    (q_neg),
        .done     (div_done)
    );

    // Output register: load on retire, drop on a completed result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (retire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_item_reg <= item;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

    // A sample transaction starts a full program pass, so none follows directly
    `IIR_ASSERT_CLK(a_no_back_to_back, (samples.valid && samples.ready) |=> !samples.ready, "sample taken twice in a row")
    // A retire never overwrites a result that is still waiting
    `IIR_ASSERT_NEVER(a_no_overwrite, retire && out_valid_reg && !results.ready, "pending result overwritten")
    // Retire only after the divider has produced every quotient bit
    `IIR_ASSERT_CLK(a_div_before_retire, retire |-> div_done, "retire before divide finished")
    // A zero divisor never reports saturation as well
    `IIR_ASSERT_NEVER(a_flags_exclusive, out_valid_reg && out_item_reg.saturated && out_item_reg.divisor_zero, "both result flags set")

endmodule

// ===== tb/sv/tb_iir_direct_form_one_filter_unit.sv =====
// Self-checking testbench for the direct form I IIR filter unit.
// Drives samples and coefficient writes, predicts every filtered sample on its own.
// Depends on iir_pkg, iir_stream_if and iir_direct_form_one_filter_unit.
module tb_iir_direct_form_one_filter_unit;
    import iir_pkg::*;

    // Filter order of the instance; the predictor uses the same clamped tap count
    localparam int FILTER_ORDER = 3;
    localparam int HIST         = 3;
    localparam int TAPS         = (FILTER_ORDER < 0) ? 0
                                : ((FILTER_ORDER > HIST) ? HIST : FILTER_ORDER);

    // Register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] CFG_B0       = REG_IDX_W'(REG_B0);
    localparam logic [REG_IDX_W-1:0] CFG_B1       = 4'd1;
    localparam logic [REG_IDX_W-1:0] CFG_B2       = 4'd2;
    localparam logic [REG_IDX_W-1:0] CFG_B3       = 4'd3;
    localparam logic [REG_IDX_W-1:0] CFG_A0       = REG_IDX_W'(REG_A0);
    localparam logic [REG_IDX_W-1:0] CFG_A1       = 4'd5;
    localparam logic [REG_IDX_W-1:0] CFG_A2       = 4'd6;
    localparam logic [REG_IDX_W-1:0] CFG_A3       = 4'd7;
    // Indexes past the register bank; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] CFG_STRAY_LO = 4'd8;
    localparam logic [REG_IDX_W-1:0] CFG_STRAY_HI = 4'd15;

    localparam logic [COEF_W-1:0] COEF_MAX = 24'h7FFFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;

    // Run shape
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 140;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off in pressure phases
    localparam int TAIL_CYCLES  = 64;    // wind-down watch for stray results
    localparam int STALL_LIMIT  = 4000;  // cycles with no transaction before giving up
    localparam int REPORT_LIMIT = 10;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef enum logic [2:0] {
        STYLE_GENTLE,
        STYLE_LOW_ORDER,
        STYLE_WILD,
        STYLE_EXTREME,
        STYLE_NO_DIVISOR
    } coef_style_t;

    // One line of the directed table: a sample transaction or a register write
    typedef struct {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [COEF_W-1:0]      data;
        sample_t                x;
        bit                     fixed;
        out_item_t              want;
    } drill_row_t;

    // One filtered sample still owed by the block
    typedef struct {
        out_item_t predicted;
        bit        fixed;
        out_item_t fixed_value;
        int        serial;
    } owed_sample_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    iir_stream_if #(.payload_t(in_item_t))  samples_if ();
    iir_stream_if #(.payload_t(out_item_t)) results_if ();

    iir_direct_form_one_filter_unit #(
        .ORDER(FILTER_ORDER)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_if),
        .results(results_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow of the filter: coefficients and the two delay lines
    coef_t   coef_bank [NREGS];
    sample_t x_hist [HIST];
    sample_t y_hist [HIST];

    owed_sample_t owed_samples [$];

    // Typed-in expectation that travels with the current sample transaction
    bit        row_fixed;
    out_item_t row_fixed_value;

    // Idling controls shared by the two sides
    int gap_max   = 19;
    int stall_max = 19;
    bit hold_request;

    logic [COEF_W-1:0] bank_plan [NREGS];

    int mismatch_count;
    int accepted_samples;
    int checked_results;
    int clamped_results;
    int zero_div_results;
    int reg_writes;
    int quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow filter: one sample in, one filtered sample out, delay lines advance.
    // The Q8.16 scale of the coefficients cancels in the division by a0.
    function automatic out_item_t filter_step(sample_t x);
        longint    sum;
        longint    divisor;
        longint    quo;
        out_item_t r;
        sum = longint'(coef_bank[CFG_B0]) * longint'(x);
        for (int k = 0; k < TAPS; k++)
        begin
            sum += longint'(coef_bank[CFG_B1 + k]) * longint'(x_hist[k]);
            sum -= longint'(coef_bank[CFG_A1 + k]) * longint'(y_hist[k]);
        end
        divisor        = longint'(coef_bank[CFG_A0]);
        r.saturated    = 1'b0;
        r.divisor_zero = 1'b0;
        if (divisor == 0)
        begin
            // zero divisor: emit and store 0, flag it
            r.divisor_zero = 1'b1;
            r.sample_out   = '0;
        end
        else
        begin
            // SV integer division truncates toward zero
            quo = sum / divisor;
            if (quo > longint'(SAMPLE_MAX))
            begin
                quo         = longint'(SAMPLE_MAX);
                r.saturated = 1'b1;
            end
            else if (quo < longint'(SAMPLE_MIN))
            begin
                quo         = longint'(SAMPLE_MIN);
                r.saturated = 1'b1;
            end
            r.sample_out = sample_t'(quo);
        end
        // advance both delay lines; the stored output is the clamped one
        for (int k = HIST - 1; k > 0; k--)
        begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = r.sample_out;
        return r;
    endfunction

    function automatic bit same_item(out_item_t a, out_item_t b);
        return (a.sample_out === b.sample_out) && (a.saturated === b.saturated)
            && (a.divisor_zero === b.divisor_zero);
    endfunction

    function automatic int rand_signed(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly full-range noise, with extremes and small values mixed in
    function automatic sample_t rand_sample();
        sample_t s;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       s = SAMPLE_MAX;
                    1:       s = SAMPLE_MIN;
                    2:       s = '0;
                    default: s = -16'sd1;
                endcase
            end
            1, 2:    s = sample_t'(rand_signed(300));
            default: s = sample_t'($urandom());
        endcase
        return s;
    endfunction

    function automatic drill_row_t smp(sample_t x);
        drill_row_t row;
        row.kind  = ROW_SAMPLE;
        row.idx   = '0;
        row.data  = '0;
        row.x     = x;
        row.fixed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic drill_row_t pin(sample_t x, sample_t y, logic sat, logic dz);
        drill_row_t row;
        row                   = smp(x);
        row.fixed             = 1'b1;
        row.want.sample_out   = y;
        row.want.saturated    = sat;
        row.want.divisor_zero = dz;
        return row;
    endfunction

    function automatic drill_row_t wr(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        drill_row_t row;
        row      = smp('0);
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    task automatic note_mismatch(string what, int serial, out_item_t want, out_item_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH (%s) sample #%0d: expected out=%0d sat=%b dz=%b, got out=%0d sat=%b dz=%b",
                     what, serial, $signed(want.sample_out), want.saturated, want.divisor_zero,
                     $signed(got.sample_out), got.saturated, got.divisor_zero);
    endtask

    // Draw a coefficient set of the given flavor into bank_plan
    task automatic pick_bank(coef_style_t style);
        // default flavor: small feedback, so outputs mostly stay in range
        for (int r = 0; r < NREGS; r++)
            bank_plan[r] = COEF_W'(rand_signed((r < CFG_A0) ? 24576 : 12288));
        bank_plan[CFG_A0] = COEF_W'(65536 + rand_signed(32768));
        case (style)
            STYLE_LOW_ORDER:
            begin
                // lower orders are reached by zeroing the far taps
                bank_plan[CFG_B3] = '0;
                bank_plan[CFG_A3] = '0;
                if ($urandom_range(1))
                begin
                    bank_plan[CFG_B2] = '0;
                    bank_plan[CFG_A2] = '0;
                end
            end
            STYLE_WILD:
            begin
                for (int r = 0; r < NREGS; r++)
                    bank_plan[r] = COEF_W'($urandom());
            end
            STYLE_EXTREME:
            begin
                for (int r = 0; r < NREGS; r++)
                begin
                    case ($urandom_range(5))
                        0:       bank_plan[r] = COEF_MAX;
                        1:       bank_plan[r] = COEF_MIN;
                        2:       bank_plan[r] = '0;
                        3:       bank_plan[r] = COEF_W'(1);
                        4:       bank_plan[r] = '1;
                        default: bank_plan[r] = COEF_ONE;
                    endcase
                end
            end
            STYLE_NO_DIVISOR: bank_plan[CFG_A0] = '0;
            default: ;
        endcase
    endtask

    // Drop valid and hold until every owed sample has come back
    task automatic drain();
        samples_if.valid <= 1'b0;
        while (owed_samples.size() != 0)
            @(negedge clk);
    endtask

    // Write one register; cfg_we stays high so back-to-back writes need no gap
    task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Offer one sample transaction after a random gap and hold it until taken
    task automatic send_sample(sample_t x, bit fixed, out_item_t want);
        int gap;
        gap = $urandom_range(gap_max);
        if (cfg_we)
            cfg_we <= 1'b0;
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.payload <= '{sample_in: x};
        row_fixed          <= fixed;
        row_fixed_value    <= want;
        samples_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!(samples_if.valid && samples_if.ready));
        @(negedge clk);
    endtask

    // Monitor: mirror register writes, predict on each accepted sample,
    // check each accepted result against the oldest owed sample.
    always @(posedge clk)
    begin : monitor
        owed_sample_t entry;
        out_item_t    got;
        bit           moved;
        if (!rst_n)
        begin
            for (int r = 0; r < NREGS; r++)
                coef_bank[r] = '0;
            coef_bank[CFG_B0] = coef_t'(COEF_ONE);
            coef_bank[CFG_A0] = coef_t'(COEF_ONE);
            for (int k = 0; k < HIST; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            quiet_cycles <= 0;
        end
        else
        begin
            moved = 1'b0;
            if (cfg_we)
            begin
                reg_writes++;
                // indexes past the bank are dropped by the block
                if (cfg_index < NREGS)
                    coef_bank[cfg_index[2:0]] = coef_t'(cfg_data);
            end
            if (samples_if.valid && samples_if.ready)
            begin
                entry.predicted   = filter_step(samples_if.payload.sample_in);
                entry.fixed       = row_fixed;
                entry.fixed_value = row_fixed_value;
                entry.serial      = accepted_samples;
                owed_samples.push_back(entry);
                accepted_samples++;
                moved = 1'b1;
            end
            if (results_if.valid && results_if.ready)
            begin
                got   = results_if.payload;
                moved = 1'b1;
                if (owed_samples.size() == 0)
                    note_mismatch("unexpected", -1, '0, got);
                else
                begin
                    entry = owed_samples.pop_front();
                    if (!same_item(entry.predicted, got))
                        note_mismatch("predicted", entry.serial, entry.predicted, got);
                    if (entry.fixed && !same_item(entry.fixed_value, got))
                        note_mismatch("directed", entry.serial, entry.fixed_value, got);
                end
                checked_results++;
                if (got.saturated)
                    clamped_results++;
                if (got.divisor_zero)
                    zero_div_results++;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // Result side: random stall per transaction, or one long hold-off on request
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                stall = $urandom_range(stall_max);
                if (stall > 0)
                begin
                    results_if.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            results_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(results_if.valid && results_if.ready));
            @(negedge clk);
        end
    end

    // Watchdog: end the run when the block stops moving transactions
    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no transaction for %0d cycles, %0d samples still owed",
                 STALL_LIMIT, owed_samples.size());
        $display("tb_iir_direct_form_one_filter_unit: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        drill_row_t  drill_rows [$];
        coef_style_t style;

        // known values on every input before reset
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        samples_if.valid   = 1'b0;
        samples_if.payload = '0;
        results_if.ready   = 1'b0;
        row_fixed          = 1'b0;
        row_fixed_value    = '0;
        hold_request       = 1'b0;

        // Directed table. Rows with a typed result are read straight off the
        // filter equation: with only b0 and a0 set, y = b0 * x / a0.
        // Reset values: b0 = a0 = 1.0, so the filter passes samples through
        drill_rows.push_back(pin('0, '0, 1'b0, 1'b0));
        drill_rows.push_back(pin(SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0));
        drill_rows.push_back(pin(SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0));
        drill_rows.push_back(pin(16'sd1, 16'sd1, 1'b0, 1'b0));
        drill_rows.push_back(pin(-16'sd1, -16'sd1, 1'b0, 1'b0));
        // largest gain: both signs clamp
        drill_rows.push_back(wr(CFG_B0, COEF_MAX));
        drill_rows.push_back(pin(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0));
        drill_rows.push_back(pin(SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b0));
        drill_rows.push_back(pin('0, '0, 1'b0, 1'b0));
        // most negative gain: clamps to the opposite rail
        drill_rows.push_back(wr(CFG_B0, COEF_MIN));
        drill_rows.push_back(pin(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0));
        drill_rows.push_back(pin(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0));
        // zero divisor forces 0 and raises the flag
        drill_rows.push_back(wr(CFG_A0, '0));
        drill_rows.push_back(pin(16'sd12345, '0, 1'b0, 1'b1));
        drill_rows.push_back(pin(SAMPLE_MIN, '0, 1'b0, 1'b1));
        // b0 = a0 = most negative: unity gain again, no clamp
        drill_rows.push_back(wr(CFG_A0, COEF_MIN));
        drill_rows.push_back(pin(SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0));
        drill_rows.push_back(pin(SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0));
        // writes past the bank must not land anywhere
        drill_rows.push_back(wr(CFG_STRAY_LO, '0));
        drill_rows.push_back(wr(CFG_STRAY_HI, '1));
        drill_rows.push_back(pin(16'sd100, 16'sd100, 1'b0, 1'b0));
        // full third-order filter with feedback; checked by the shadow filter
        drill_rows.push_back(wr(CFG_B0, COEF_W'(32768)));
        drill_rows.push_back(wr(CFG_B1, COEF_W'(32768)));
        drill_rows.push_back(wr(CFG_B2, COEF_W'(-16384)));
        drill_rows.push_back(wr(CFG_B3, COEF_W'(8192)));
        drill_rows.push_back(wr(CFG_A0, COEF_ONE));
        drill_rows.push_back(wr(CFG_A1, COEF_W'(-49152)));
        drill_rows.push_back(wr(CFG_A2, COEF_W'(8192)));
        drill_rows.push_back(wr(CFG_A3, COEF_W'(-4096)));
        drill_rows.push_back(smp(SAMPLE_MAX));
        drill_rows.push_back(smp(SAMPLE_MIN));
        drill_rows.push_back(smp(16'sd1000));
        drill_rows.push_back(smp('0));
        drill_rows.push_back(smp('0));
        drill_rows.push_back(smp(-16'sd1));
        drill_rows.push_back(smp('0));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the table; registers change only once the block is idle
        foreach (drill_rows[i])
        begin
            if (drill_rows[i].kind == ROW_WRITE)
            begin
                drain();
                cfg_write(drill_rows[i].idx, drill_rows[i].data);
            end
            else
                send_sample(drill_rows[i].x, drill_rows[i].fixed, drill_rows[i].want);
        end

        // Random phases: a fresh coefficient set each, cycling through the flavors
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            style = coef_style_t'(p % 5);
            pick_bank(style);
            for (int r = 0; r < NREGS; r++)
                cfg_write(REG_IDX_W'(r), bank_plan[r]);
            if ($urandom_range(1))
                cfg_write(REG_IDX_W'($urandom_range(CFG_STRAY_HI, CFG_STRAY_LO)),
                          COEF_W'($urandom()));

            // every third phase runs with no idling on either side
            if (p % 3 == 2)
            begin
                gap_max   = 0;
                stall_max = 0;
            end
            else
            begin
                gap_max   = 19;
                stall_max = 19;
            end
            // pressure: receiver holds off while samples keep coming back to back
            if (p == 1 || p == 7)
            begin
                gap_max      = 0;
                hold_request = 1'b1;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // now and then pause until the block has emptied
                if ($urandom_range(63) == 0)
                    drain();
                send_sample(rand_sample(), 1'b0, '0);
            end
        end

        // Wind down: collect every owed sample, then watch for strays
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d samples over %0d register writes; %0d results checked,",
                 accepted_samples, reg_writes, checked_results);
        $display("%0d of them clamped and %0d with a zero divisor; %0d mismatches.",
                 clamped_results, zero_div_results, mismatch_count);
        if (mismatch_count == 0 && owed_samples.size() == 0)
            $display("tb_iir_direct_form_one_filter_unit: PASS");
        else
            $display("tb_iir_direct_form_one_filter_unit: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/iir_pkg.sv
rtl/core/iir_stream_if.sv
rtl/core/iir_seq.sv
rtl/core/iir_div.sv
rtl/core/iir_dp.sv
rtl/core/iir_direct_form_one_filter_unit.sv
tb/sv/tb_iir_direct_form_one_filter_unit.sv
